/* rtl/core/crtb_pkg.sv */
package crtb_pkg;

  localparam int unsigned NUM_TIMERS = 4;
  localparam int unsigned TIMER_IDX_W = 2;
  localparam int unsigned CYC_W = 13;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned REM_W = 10;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned N_W = 14;
  localparam int unsigned SPAN_W = 17;
  localparam int unsigned OUT_OVF_W = 13;
  localparam int unsigned CTL_W = 5;
  localparam int unsigned CTL_REG_W = 20;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = 4;

  localparam logic [CYC_W-1:0] MAX_STEP = 13'd4096;
  localparam logic [SPAN_W-1:0] PERIOD_FULL = 17'h10000;
  localparam logic [N_W-1:0] OVF_SAT = 14'h1FFF;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CONTROLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 2'd1;

  // Per-timer control field, enable in the low bit
  typedef struct packed {
    logic [1:0] sel;
    logic       ie;
    logic       cas;
    logic       en;
  } tctl_t;

  typedef struct packed {
    logic                  start;
    logic [N_W-1:0]        dividend;
    logic [SPAN_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] quot;
    logic [N_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [LEN_W-1:0] tick_len(input logic [1:0] sel);
    logic [LEN_W-1:0] len;
    case (sel)
      2'd0:    len = 11'd1;
      2'd1:    len = 11'd64;
      2'd2:    len = 11'd256;
      default: len = 11'd1024;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] tick_shift(input logic [1:0] sel);
    logic [3:0] sh;
    case (sel)
      2'd0:    sh = 4'd0;
      2'd1:    sh = 4'd6;
      2'd2:    sh = 4'd8;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

/* rtl/core/cascaded_reload_timer_bank_unit.sv */
// Bank of four 16-bit up-counting reload timers, advanced once per input
// transaction by elapsed_cycles (clamped to 4096). A timer that is enabled and
// not cascaded counts through its prescaler (1, 64, 256 or 1024) and keeps the
// leftover cycles; a cascaded timer counts the overflows of the timer below
// it. On overflow a counter restarts from its reload value, and surplus
// increments wrap modulo (0x10000 - reload). Each transaction yields exactly
// one result: the interrupt bits, the overflow count of every timer
// (saturated at 8191) and the counters after the step. The timers are handled
// one after another by a small sequencer around one shared restoring divider
// that resolves the wrap. Each timer passes an evaluate state and a next
// state; one that takes an increment also passes a bump state, and one that
// overflows waits in a divide state while the divider runs its 14 one-bit
// iterations. A done state then loads the output register once it is free.
// in_ready_o is high only while the sequencer is idle, which includes the
// time a finished result still waits in the output register. Configuration
// is written through cfg_we_i / cfg_idx_i / cfg_wdata_i: index 0 holds the
// timer controls (five bits per timer: enable, cascade, interrupt enable,
// two-bit prescaler), index 1 the four reload values, timer 0 in the low bits;
// other indexes are dropped.
module cascaded_reload_timer_bank_unit import crtb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CYC_W-1:0]     elapsed_cycles_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           irq_bits_o,
  output logic [OUT_OVF_W-1:0] overflows_timer0_o,
  output logic [OUT_OVF_W-1:0] overflows_timer1_o,
  output logic [OUT_OVF_W-1:0] overflows_timer2_o,
  output logic [OUT_OVF_W-1:0] overflows_timer3_o,
  output logic [CNT_W-1:0]     count_timer0_o,
  output logic [CNT_W-1:0]     count_timer1_o,
  output logic [CNT_W-1:0]     count_timer2_o,
  output logic [CNT_W-1:0]     count_timer3_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_BUMP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_NEXT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // Configuration
  logic [CTL_REG_W-1:0] controls_q;
  logic [CFG_W-1:0]     reloads_q;

  // Timer state
  logic [CNT_W-1:0] counters_q [NUM_TIMERS];
  logic [REM_W-1:0] rems_q [NUM_TIMERS];

  // Sequencer
  logic [2:0]             state_q, state_d;
  logic [TIMER_IDX_W-1:0] idx_q, idx_d;
  logic [CYC_W-1:0]       cycles_q, cycles_d;
  logic [N_W-1:0]         n_q, n_d;
  logic [N_W-1:0]         ovf_q, ovf_d;
  logic [N_W-1:0]         carry_q, carry_d;
  logic [N_W-1:0]         ovfs_q [NUM_TIMERS];
  logic [3:0]             irq_q, irq_d;

  // Output register
  logic                 out_valid_q;
  logic [3:0]           out_irq_q;
  logic [N_W-1:0]       out_ovf_q [NUM_TIMERS];
  logic [CNT_W-1:0]     out_cnt_q [NUM_TIMERS];

  // Per-step write strobes into the timer state
  logic             cnt_we, rem_we, ovf_we, out_load;
  logic [CNT_W-1:0] cnt_wdata;
  logic [REM_W-1:0] rem_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Current timer view
  tctl_t             ctl;
  logic [CNT_W-1:0]  rel;
  logic [CNT_W-1:0]  cnt;
  logic [LEN_W-1:0]  len;
  logic [CYC_W-1:0]  have;
  logic [CYC_W-1:0]  left;
  logic [SPAN_W-1:0] to_ovf;
  logic [SPAN_W-1:0] span;

  logic in_fire;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  assign ctl    = tctl_t'(controls_q[CTL_W*idx_q +: CTL_W]);
  assign rel    = reloads_q[CNT_W*idx_q +: CNT_W];
  assign cnt    = counters_q[idx_q];
  assign len    = tick_len(ctl.sel);
  assign have   = cycles_q + {{(CYC_W-REM_W){1'b0}}, rems_q[idx_q]};
  assign left   = have - {{(CYC_W-LEN_W){1'b0}}, len};
  assign to_ovf = PERIOD_FULL - {1'b0, cnt};
  assign span   = PERIOD_FULL - {1'b0, rel};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cycles_d  = cycles_q;
    n_d       = n_q;
    ovf_d     = ovf_q;
    carry_d   = carry_q;
    irq_d     = irq_q;
    cnt_we    = 1'b0;
    cnt_wdata = cnt;
    rem_we    = 1'b0;
    rem_wdata = '0;
    ovf_we    = 1'b0;
    out_load  = 1'b0;
    div_req   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // clamp long steps and start with timer 0
          cycles_d = (elapsed_cycles_i > MAX_STEP) ? MAX_STEP : elapsed_cycles_i;
          idx_d    = '0;
          carry_d  = '0;
          irq_d    = '0;
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ovf_d   = '0;
        state_d = ST_NEXT;
        if (ctl.en && !ctl.cas) begin
          rem_we = 1'b1;
          if (have >= {{(CYC_W-LEN_W){1'b0}}, len}) begin
            // a stale remainder still yields at least one increment
            n_d       = N_W'(1) + {1'b0, left >> tick_shift(ctl.sel)};
            rem_wdata = left[REM_W-1:0] & REM_W'(len - 1'b1);
            state_d   = ST_BUMP;
          end else begin
            rem_wdata = have[REM_W-1:0];
          end
        end else if (ctl.en && ctl.cas && (carry_q != '0)) begin
          // several cascaded increments drop the kept remainder
          n_d = carry_q;
          if (carry_q > N_W'(1)) begin
            rem_we    = 1'b1;
            rem_wdata = '0;
          end
          state_d = ST_BUMP;
        end
      end
      ST_BUMP: begin
        if ({{(SPAN_W-N_W){1'b0}}, n_q} >= to_ovf) begin
          // overflow: wrap the surplus modulo the reload span
          div_req.start    = 1'b1;
          div_req.dividend = N_W'({{(SPAN_W-N_W){1'b0}}, n_q} - to_ovf);
          div_req.divisor  = span;
          state_d          = ST_DIV;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt + {{(CNT_W-N_W){1'b0}}, n_q};
          state_d   = ST_NEXT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          cnt_we    = 1'b1;
          cnt_wdata = rel + {{(CNT_W-N_W){1'b0}}, div_rsp.rem};
          ovf_d     = div_rsp.quot + N_W'(1);
          state_d   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        ovf_we  = 1'b1;
        carry_d = ovf_q;
        if ((ovf_q != '0) && ctl.ie) begin
          irq_d[idx_q] = 1'b1;
        end
        if (idx_q == TIMER_IDX_W'(NUM_TIMERS - 1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      controls_q  <= '0;
      reloads_q   <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        counters_q[i] <= '0;
        rems_q[i]     <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i == REG_CONTROLS)) begin
        controls_q <= cfg_wdata_i[CTL_REG_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_RELOAD)) begin
        reloads_q <= cfg_wdata_i;
      end
      if (cnt_we) begin
        counters_q[idx_q] <= cnt_wdata;
      end
      if (rem_we) begin
        rems_q[idx_q] <= rem_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cycles_q <= cycles_d;
    n_q      <= n_d;
    ovf_q    <= ovf_d;
    carry_q  <= carry_d;
    irq_q    <= irq_d;
    if (ovf_we) begin
      ovfs_q[idx_q] <= ovf_q;
    end
    if (out_load) begin
      out_irq_q <= irq_q;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        out_ovf_q[i] <= (ovfs_q[i] > OVF_SAT) ? OVF_SAT : ovfs_q[i];
        out_cnt_q[i] <= counters_q[i];
      end
    end
  end

  crtb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o        = out_valid_q;
  assign irq_bits_o         = out_irq_q;
  assign overflows_timer0_o = out_ovf_q[0][OUT_OVF_W-1:0];
  assign overflows_timer1_o = out_ovf_q[1][OUT_OVF_W-1:0];
  assign overflows_timer2_o = out_ovf_q[2][OUT_OVF_W-1:0];
  assign overflows_timer3_o = out_ovf_q[3][OUT_OVF_W-1:0];
  assign count_timer0_o     = out_cnt_q[0];
  assign count_timer1_o     = out_cnt_q[1];
  assign count_timer2_o     = out_cnt_q[2];
  assign count_timer3_o     = out_cnt_q[3];

  a_start_at_timer0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EVAL) && (idx_q == '0))
    else $error("transaction did not start at timer 0");

  a_div_only_from_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == ST_BUMP) ##1 (state_q == ST_DIV))
    else $error("divider started outside the bump step");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && (state_q == ST_IDLE))
    else $error("result register not loaded on completion");

  a_cnt_write_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (state_q == ST_BUMP) || (state_q == ST_DIV && div_rsp.done))
    else $error("counter written outside a bump");

endmodule

/* rtl/core/crtb_div.sv */
// Restoring divider, one quotient bit per cycle.
module crtb_div import crtb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [N_W-1:0]       dvd_q, dvd_d;
  logic [N_W-1:0]       rem_q, rem_d;
  logic [SPAN_W-1:0]    dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [N_W:0]         partial;
  logic                 fits;

  assign partial = {rem_q, dvd_q[N_W-1]};
  assign fits = {{(SPAN_W-N_W-1){1'b0}}, partial} >= dsr_q;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = DIV_CNT_W'(N_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (fits) begin
        rem_d = N_W'(partial - dsr_q[N_W:0]);
      end else begin
        rem_d = partial[N_W-1:0];
      end
      dvd_d = {dvd_q[N_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q) && !busy_q)
    else $error("divider done without a running division");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> {{(SPAN_W-N_W){1'b0}}, rem_q} < dsr_q)
    else $error("divider remainder not below divisor");

endmodule

/* verif/cascaded_reload_timer_bank_unit_tb.sv */
`timescale 1ns / 1ps

module cascaded_reload_timer_bank_unit_tb import crtb_pkg::*;;

  // Spare register indexes: writes there must leave the bank untouched
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned STEPS_PER_PHASE = 36;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP = 50;

  // One result transaction: interrupt bits, saturated overflow counts, counters
  typedef struct packed {
    logic [3:0]                           irq;
    logic [NUM_TIMERS-1:0][OUT_OVF_W-1:0] ovf;
    logic [NUM_TIMERS-1:0][CNT_W-1:0]     cnt;
  } bank_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CYC_W-1:0]     elapsed_cycles_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [3:0]           irq_bits_o;
  logic [OUT_OVF_W-1:0] overflows_timer0_o;
  logic [OUT_OVF_W-1:0] overflows_timer1_o;
  logic [OUT_OVF_W-1:0] overflows_timer2_o;
  logic [OUT_OVF_W-1:0] overflows_timer3_o;
  logic [CNT_W-1:0]     count_timer0_o;
  logic [CNT_W-1:0]     count_timer1_o;
  logic [CNT_W-1:0]     count_timer2_o;
  logic [CNT_W-1:0]     count_timer3_o;

  cascaded_reload_timer_bank_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .elapsed_cycles_i   (elapsed_cycles_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .irq_bits_o         (irq_bits_o),
    .overflows_timer0_o (overflows_timer0_o),
    .overflows_timer1_o (overflows_timer1_o),
    .overflows_timer2_o (overflows_timer2_o),
    .overflows_timer3_o (overflows_timer3_o),
    .count_timer0_o     (count_timer0_o),
    .count_timer1_o     (count_timer1_o),
    .count_timer2_o     (count_timer2_o),
    .count_timer3_o     (count_timer3_o)
  );

  // Shadow of the bank: registers as last written, counters and kept remainders
  logic [CTL_REG_W-1:0] ctl_shadow = '0;
  logic [CFG_W-1:0]     reload_shadow = '0;
  logic [CNT_W-1:0]     tmr_count [NUM_TIMERS];
  logic [REM_W-1:0]     tmr_residue [NUM_TIMERS];

  logic [CYC_W-1:0] pending_steps [$];
  bank_result_t     expected_results [$];

  // Pacing knobs, owned by the stimulus block and read by driver and monitor
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          quiet_tail = 1'b0;
  int unsigned hold_requests = 0;

  int unsigned steps_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_count[i] = '0;
      tmr_residue[i] = '0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic tctl_t timer_ctl(input logic en, input logic cas, input logic ie,
                                      input logic [1:0] sel);
    tctl_t c;
    c.en = en;
    c.cas = cas;
    c.ie = ie;
    c.sel = sel;
    return c;
  endfunction

  // Add n increments to timer t; return how many times it wrapped.
  // After the first wrap the counter lives in [reload, 0xFFFF], so the rest
  // of the increments wrap modulo (0x10000 - reload).
  function automatic int unsigned add_ticks(input int t, input int unsigned n);
    int unsigned cnt;
    int unsigned rel;
    int unsigned span;
    int unsigned ovf;
    int unsigned rest;
    int unsigned sum;
    cnt = tmr_count[t];
    rel = reload_shadow[CNT_W*t +: CNT_W];
    ovf = 0;
    rest = n;
    if (rest >= PERIOD_FULL - cnt) begin
      rest = rest - (PERIOD_FULL - cnt);
      span = PERIOD_FULL - rel;
      ovf = 1 + rest / span;
      rest = rest % span;
      cnt = rel;
    end
    sum = cnt + rest;
    tmr_count[t] = sum[CNT_W-1:0];
    return ovf;
  endfunction

  // Advance the shadow bank by one step and queue the result it must produce
  task automatic advance_timer_bank(input logic [CYC_W-1:0] cyc_in);
    int unsigned  cycles;
    int unsigned  carry;
    int unsigned  have;
    int unsigned  shift;
    int unsigned  len;
    int unsigned  left;
    int unsigned  ovf;
    int           t;
    tctl_t        ctl;
    bank_result_t res;
    cycles = cyc_in;
    if (cycles > MAX_STEP) cycles = MAX_STEP;
    carry = 0;
    res = '0;
    for (t = 0; t < NUM_TIMERS; t++) begin
      ctl = ctl_shadow[CTL_W*t +: CTL_W];
      ovf = 0;
      if (ctl.en && !ctl.cas) begin
        // prescaler period is 2^0, 2^6, 2^8 or 2^10
        shift = (ctl.sel == 2'd0) ? 0 : 4 + 2 * ctl.sel;
        len = 1 << shift;
        have = cycles + tmr_residue[t];
        if (have >= len) begin
          left = have - len;
          ovf = add_ticks(t, 1 + (left >> shift));
          left = left & (len - 1);
          tmr_residue[t] = left[REM_W-1:0];
        end else begin
          tmr_residue[t] = have[REM_W-1:0];
        end
      end else if (ctl.en && ctl.cas && carry > 0) begin
        // a single carried increment keeps the remainder, more clear it
        if (carry > 1) tmr_residue[t] = '0;
        ovf = add_ticks(t, carry);
      end
      if (ovf > 0 && ctl.ie) res.irq[t] = 1'b1;
      res.ovf[t] = (ovf > OVF_SAT) ? OVF_SAT[OUT_OVF_W-1:0] : ovf[OUT_OVF_W-1:0];
      carry = ovf;
    end
    for (t = 0; t < NUM_TIMERS; t++) res.cnt[t] = tmr_count[t];
    expected_results.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
               $time, results_checked, what, got, want);
    mismatches++;
  endtask

  task automatic compare_result(input bank_result_t got, input bank_result_t want);
    if (got.irq !== want.irq)
      flag_mismatch("irq_bits", longint'(got.irq), longint'(want.irq));
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (got.ovf[t] !== want.ovf[t])
        flag_mismatch($sformatf("overflows_timer%0d", t), longint'(got.ovf[t]),
                      longint'(want.ovf[t]));
      if (got.cnt[t] !== want.cnt[t])
        flag_mismatch($sformatf("count_timer%0d", t), longint'(got.cnt[t]),
                      longint'(want.cnt[t]));
    end
  endtask

  // Driver: offer queued steps, hold valid and payload until the bank accepts
  // the step, and insert random idle bursts between transactions.
  always @(posedge clk_i) begin : step_driver
    logic             nxt_valid;
    logic [CYC_W-1:0] nxt_cyc;
    int unsigned      gap_left;
    nxt_valid = in_valid_i;
    nxt_cyc = elapsed_cycles_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        // predict on acceptance: registers only change while the bank is idle
        advance_timer_bank(elapsed_cycles_i);
        steps_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_steps.size() > 0) begin
          if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
            gap_left = $urandom_range(1, 15) - 1;
          end else begin
            nxt_valid = 1'b1;
            nxt_cyc = pending_steps.pop_front();
          end
        end
      end
    end else begin
      gap_left = 0;
    end
    in_valid_i <= nxt_valid;
    elapsed_cycles_i <= nxt_cyc;
  end

  // Monitor: check every completed result transaction against the oldest
  // expectation and drive out_ready with random stalls and the long hold.
  always @(posedge clk_i) begin : result_monitor
    bank_result_t got;
    logic         rdy_nxt;
    int unsigned  stall_left;
    int unsigned  hold_left;
    int unsigned  holds_done;
    rdy_nxt = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.irq = irq_bits_o;
        got.ovf = {overflows_timer3_o, overflows_timer2_o, overflows_timer1_o,
                   overflows_timer0_o};
        got.cnt = {count_timer3_o, count_timer2_o, count_timer1_o, count_timer0_o};
        if (expected_results.size() == 0)
          flag_mismatch("unexpected result", longint'(got.cnt), longint'(0));
        else compare_result(got, expected_results.pop_front());
        results_checked++;
      end
      // start a requested long hold so the bank backs up into its input
      if (holds_done != hold_requests && hold_left == 0) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 99) < recv_stall_pct) begin
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        rdy_nxt = 1'b1;
      end
    end else begin
      stall_left = 0;
      hold_left = 0;
      holds_done = 0;
    end
    out_ready_i <= rdy_nxt;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still pending",
               cycle_count, expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Write one register through the configuration port and update its shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_CONTROLS: ctl_shadow = data[CTL_REG_W-1:0];
      REG_RELOAD:   reload_shadow = data;
      default:      ;
    endcase
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the sender until the bank has returned every expected result
  task automatic wait_bank_idle();
    do @(negedge clk_i);
    while (pending_steps.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  function automatic logic [CYC_W-1:0] pick_cycles();
    logic [CYC_W-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = '0;
      1:       c = MAX_STEP;
      2:       c = CYC_W'($urandom_range(4097, 8191));
      3, 4:    c = CYC_W'($urandom_range(0, 70));
      default: c = CYC_W'($urandom_range(0, 4096));
    endcase
    return c;
  endfunction

  // Bias reloads high so that wrapped timers overflow often
  function automatic logic [CNT_W-1:0] pick_reload();
    logic [CNT_W-1:0] r;
    case ($urandom_range(0, 7))
      0:       r = '0;
      1:       r = '1;
      2, 3:    r = CNT_W'($urandom_range(16'hFF00, 16'hFFFF));
      4:       r = CNT_W'($urandom_range(16'hC000, 16'hFFFF));
      default: r = CNT_W'($urandom());
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_pacing();
    int unsigned p;
    case ($urandom_range(0, 2))
      0:       p = 5;
      1:       p = 20;
      default: p = 50;
    endcase
    return p;
  endfunction

  initial begin : stimulus
    logic [CTL_REG_W-1:0] ctl_word;
    logic [CFG_W-1:0]     reload_word;
    logic [CFG_W-1:0]     wdata;
    tctl_t                c;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk timer 0 (prescaler 1) up to its first wrap, landing exactly on it,
    // then into its reload span; timer 1 counts the carries, timer 2 sits on
    // the slowest prescaler. Upper data bits of the control write are junk.
    send_gap_pct = 20;
    recv_stall_pct = 20;
    ctl_word = {timer_ctl(1'b1, 1'b1, 1'b1, 2'd0), timer_ctl(1'b1, 1'b0, 1'b1, 2'd3),
                timer_ctl(1'b1, 1'b1, 1'b1, 2'd0), timer_ctl(1'b1, 1'b0, 1'b1, 2'd0)};
    write_reg(REG_CONTROLS, {44'hFFF_FFFF_FFFF, ctl_word});
    write_reg(REG_RELOAD, {16'hFFFF, 16'h0000, 16'hFFFE, 16'hFFF0});
    pending_steps.push_back(13'd0);
    pending_steps.push_back(13'd1);
    pending_steps.push_back(13'd8191);
    pending_steps.push_back(13'd4097);
    repeat (13) pending_steps.push_back(13'd4096);
    pending_steps.push_back(13'd4095);
    pending_steps.push_back(13'd15);
    pending_steps.push_back(13'd16);
    pending_steps.push_back(13'd8191);
    wait_bank_idle();

    // Cascaded timer 0 never counts; timer 1 builds a remainder on the slow
    // prescaler, then the prescaler is lowered under it. Spare indexes get
    // all ones and must be dropped.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    ctl_word = {timer_ctl(1'b1, 1'b1, 1'b1, 2'd0), timer_ctl(1'b0, 1'b0, 1'b0, 2'd0),
                timer_ctl(1'b1, 1'b0, 1'b1, 2'd3), timer_ctl(1'b1, 1'b1, 1'b1, 2'd0)};
    write_reg(REG_CONTROLS, {44'h0, ctl_word});
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    pending_steps.push_back(13'd1000);
    wait_bank_idle();
    ctl_word[CTL_W*1 +: CTL_W] = timer_ctl(1'b1, 1'b0, 1'b1, 2'd0);
    write_reg(REG_CONTROLS, {44'h0, ctl_word});
    pending_steps.push_back(13'd0);
    wait_bank_idle();
    ctl_word[CTL_W*1 +: CTL_W] = timer_ctl(1'b1, 1'b0, 1'b1, 2'd3);
    write_reg(REG_CONTROLS, {44'h0, ctl_word});
    pending_steps.push_back(13'd1000);
    wait_bank_idle();
    ctl_word[CTL_W*1 +: CTL_W] = timer_ctl(1'b1, 1'b0, 1'b1, 2'd1);
    write_reg(REG_CONTROLS, {44'h0, ctl_word});
    pending_steps.push_back(13'd0);
    pending_steps.push_back(13'd300);
    wait_bank_idle();

    // Register extremes: all control bits set (every timer cascaded), then
    // everything cleared (every timer frozen)
    write_reg(REG_CONTROLS, '1);
    write_reg(REG_RELOAD, '1);
    pending_steps.push_back(13'd4096);
    pending_steps.push_back(13'd8191);
    wait_bank_idle();
    write_reg(REG_CONTROLS, '0);
    write_reg(REG_RELOAD, '0);
    pending_steps.push_back(13'd4096);
    pending_steps.push_back(13'd1);
    wait_bank_idle();

    // Random settings, each followed by a burst of random steps
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        c = timer_ctl($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 40,
                      $urandom_range(0, 99) < 70,
                      ($urandom_range(0, 9) < 5) ? 2'd0 : 2'($urandom_range(0, 3)));
        ctl_word[CTL_W*t +: CTL_W] = c;
        reload_word[CNT_W*t +: CNT_W] = pick_reload();
      end
      // all timers free-running on prescaler 1 with the shortest span
      if (ph == 2) begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          ctl_word[CTL_W*t +: CTL_W] = timer_ctl(1'b1, 1'b0, 1'b1, 2'd0);
          reload_word[CNT_W*t +: CNT_W] = '1;
        end
      end
      if (ph == 5) reload_word = '0;
      wdata = {$urandom(), $urandom()};
      wdata[CTL_REG_W-1:0] = ctl_word;
      write_reg(REG_CONTROLS, wdata);
      write_reg(REG_RELOAD, reload_word);
      if (ph % 4 == 1) write_reg(REG_SPARE_A, {$urandom(), $urandom()});
      if (ph % 4 == 3) write_reg(REG_SPARE_B, {$urandom(), $urandom()});

      send_gap_pct = pick_pacing();
      recv_stall_pct = pick_pacing();
      if (ph == 3) begin
        // keep offering steps while the receiver holds off for a long stretch
        send_gap_pct = 0;
        hold_requests++;
      end
      if (ph == 6) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      if (ph == RAND_PHASES - 1) quiet_tail = 1'b1;
      repeat (STEPS_PER_PHASE) pending_steps.push_back(pick_cycles());
      wait_bank_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d timer steps under %0d register writes, %0d results compared.",
             steps_accepted, reg_writes, results_checked);
    $display("Covered cascades, all prescalers, stale remainders, long steps and stalls.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
